### rtl/fpba_pkg.sv
// Shared types and codes for the fit-policy block allocator.
// No dependencies; used by fpba_cell, the top level, the checker and the bench.
package fpba_pkg;

  // Placement policy codes held in the fit_mode register (code 3 acts as first fit)
  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_mode_e;

  // Command carried in s_axis_tuser
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_ALLOC = 1'b1
  } cmd_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Control part of the candidate that travels down the cell chain
  typedef struct packed {
    logic valid;  // a scan wave is at this point of the chain
    logic found;  // some earlier cell qualified
  } cand_ctl_t;

  // APB register map
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned REG_FIT_MODE = 0;
  localparam int unsigned MODE_W       = 2;

  // Field widths on the stream ports
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned SIZE_FLD_W  = 16;
  localparam int unsigned TDATA_W     = 24;

endpackage

### rtl/fit_policy_block_allocator_unit.sv
// Top level of the fit-policy block allocator: controller, APB register
// and the chain of fpba_cell instances. Depends on fpba_pkg and fpba_cell.
//
// Usage
//   s_axis: one transfer per command. tuser[0] = command (0 load, 1 allocate),
//   tdata = {pad, size_value[15:0], block_slot[2:0]}.
//   m_axis: one transfer per command. tuser[0] = granted,
//   tdata = {pad, space_left[15:0], chosen_block[2:0]}.
//   APB: fit_mode at byte address 0 (0 first, 1 best, 2 worst, 3 as first).
// Sequencing
//   A load goes from its transfer through the done state into the output
//   register. An allocate sends a scan wave down the cell chain, one cell per
//   cycle; the winner is latched as the wave leaves the last cell, and the
//   done state then writes the table and the output register. The unit works
//   on one command at a time: the next transfer is taken only after the done
//   state has written the output register.
// Reset
//   All free-space entries clear to zero, fit_mode returns to first fit, both
//   channels go idle. No clearing pass is needed.
// Stalls
//   The result sits in an output register; a new command is still taken while
//   it waits. The table update and next result wait until that register frees.
module fit_policy_block_allocator_unit #(
  parameter int unsigned BLOCK_COUNT = 8,
  parameter int unsigned SIZE_WIDTH  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [fpba_pkg::TDATA_W-1:0]      s_axis_tdata_i,  // block_slot, size_value
  input  logic [0:0]                        s_axis_tuser_i,  // command
  // result stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [fpba_pkg::TDATA_W-1:0]      m_axis_tdata_o,  // chosen_block, space_left
  output logic [0:0]                        m_axis_tuser_o,  // granted
  // configuration
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [fpba_pkg::PADDR_W-1:0]      paddr_i,
  input  logic [31:0]                       pwdata_i,
  output logic [31:0]                       prdata_o,
  output logic                              pready_o
);

  localparam int unsigned IdxW   = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int unsigned SlotW  = fpba_pkg::SLOT_W;
  localparam int unsigned FldW   = fpba_pkg::SIZE_FLD_W;

  // ---------------- configuration register ----------------
  logic [fpba_pkg::MODE_W-1:0] mode_q;
  logic                        reg_hit;

  assign pready_o = 1'b1;
  assign reg_hit  = (paddr_i[fpba_pkg::PADDR_W-1:2] == 1'(fpba_pkg::REG_FIT_MODE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= fpba_pkg::FIT_FIRST;
    end else if (psel_i && penable_i && pwrite_i && reg_hit) begin
      mode_q <= pwdata_i[fpba_pkg::MODE_W-1:0];
    end
  end

  assign prdata_o = reg_hit ? 32'(mode_q) : 32'd0;

  // ---------------- controller ----------------
  fpba_pkg::state_e       state_q, state_d;
  logic                   cmd_q;
  logic [SlotW-1:0]       slot_q;
  logic [SIZE_WIDTH-1:0]  size_q;
  logic                   found_q;
  logic [IdxW-1:0]        pick_q;
  logic [SIZE_WIDTH-1:0]  pick_val_q;

  logic                   out_valid_q;
  logic [SlotW-1:0]       out_blk_q;
  logic [FldW-1:0]        out_left_q;
  logic                   out_ok_q;

  logic                   in_fire, out_free, finish, inject;
  logic                   res_ok;
  logic [IdxW-1:0]        wr_idx;
  logic [SIZE_WIDTH-1:0]  wr_val;
  logic [SlotW-1:0]       res_blk;
  logic [SIZE_WIDTH-1:0]  in_size, scan_req;

  // chain wiring: position k feeds cell k
  fpba_pkg::cand_ctl_t    ch_ctl [BLOCK_COUNT+1];
  logic [IdxW-1:0]        ch_idx [BLOCK_COUNT+1];
  logic [SIZE_WIDTH-1:0]  ch_val [BLOCK_COUNT+1];

  assign s_axis_tready_o = (state_q == fpba_pkg::ST_IDLE);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign finish   = (state_q == fpba_pkg::ST_DONE) && out_free;
  assign inject   = in_fire && (s_axis_tuser_i[0] == fpba_pkg::CMD_ALLOC);

  // cell 0 compares in the transfer cycle, before size_q holds the request
  assign in_size  = SIZE_WIDTH'(s_axis_tdata_i[SlotW +: FldW]);
  assign scan_req = in_fire ? in_size : size_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fpba_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = inject ? fpba_pkg::ST_SCAN : fpba_pkg::ST_DONE;
        end
      end
      fpba_pkg::ST_SCAN: begin
        if (ch_ctl[BLOCK_COUNT].valid) begin
          state_d = fpba_pkg::ST_DONE;
        end
      end
      fpba_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = fpba_pkg::ST_IDLE;
        end
      end
      default: state_d = fpba_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpba_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // command capture and scan winner
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= s_axis_tuser_i[0];
      slot_q <= s_axis_tdata_i[SlotW-1:0];
      size_q <= in_size;
    end
    if (state_q == fpba_pkg::ST_SCAN) begin
      found_q    <= ch_ctl[BLOCK_COUNT].found;
      pick_q     <= ch_idx[BLOCK_COUNT];
      pick_val_q <= ch_val[BLOCK_COUNT];
    end
  end

  // result and write-back
  always_comb begin
    if (cmd_q == fpba_pkg::CMD_LOAD) begin
      res_ok  = (32'(slot_q) < 32'(BLOCK_COUNT));
      wr_idx  = IdxW'(slot_q);
      wr_val  = size_q;
      res_blk = slot_q;
    end else begin
      res_ok  = found_q;
      wr_idx  = pick_q;
      wr_val  = pick_val_q - size_q;
      res_blk = SlotW'(pick_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_ok_q   <= res_ok;
      out_blk_q  <= res_ok ? res_blk : '0;
      out_left_q <= res_ok ? FldW'(wr_val) : '0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_ok_q;
  assign m_axis_tdata_o  = fpba_pkg::TDATA_W'({out_left_q, out_blk_q});

  // ---------------- cell chain ----------------
  assign ch_ctl[0].valid = inject;
  assign ch_ctl[0].found = 1'b0;
  assign ch_idx[0]       = '0;
  assign ch_val[0]       = '0;

  for (genvar k = 0; k < BLOCK_COUNT; k++) begin : g_cell
    logic wr_en;
    assign wr_en = finish && res_ok && (wr_idx == IdxW'(k));

    fpba_cell #(
      .SIZE_WIDTH (SIZE_WIDTH),
      .IDX_W      (IdxW),
      .CELL_IDX   (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .mode_i    (mode_q),
      .req_i     (scan_req),
      .wr_en_i   (wr_en),
      .wr_data_i (wr_val),
      .ctl_i     (ch_ctl[k]),
      .idx_i     (ch_idx[k]),
      .val_i     (ch_val[k]),
      .ctl_o     (ch_ctl[k+1]),
      .idx_o     (ch_idx[k+1]),
      .val_o     (ch_val[k+1])
    );
  end

endmodule

### rtl/fpba_cell.sv
// One cell of the allocator chain: holds one block's free space and
// passes the running best candidate to its neighbor. Depends on fpba_pkg.
module fpba_cell #(
  parameter int unsigned SIZE_WIDTH = 16,
  parameter int unsigned IDX_W      = 3,
  parameter int unsigned CELL_IDX   = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [fpba_pkg::MODE_W-1:0] mode_i,
  input  logic [SIZE_WIDTH-1:0]    req_i,
  input  logic                     wr_en_i,
  input  logic [SIZE_WIDTH-1:0]    wr_data_i,
  input  fpba_pkg::cand_ctl_t      ctl_i,
  input  logic [IDX_W-1:0]         idx_i,
  input  logic [SIZE_WIDTH-1:0]    val_i,
  output fpba_pkg::cand_ctl_t      ctl_o,
  output logic [IDX_W-1:0]         idx_o,
  output logic [SIZE_WIDTH-1:0]    val_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic [SIZE_WIDTH-1:0] space_q;
  fpba_pkg::cand_ctl_t   ctl_q, ctl_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [SIZE_WIDTH-1:0] val_q, val_d;
  logic                  qual, better, take;

  always_comb begin
    qual   = (space_q >= req_i);
    better = ((mode_i == fpba_pkg::FIT_BEST)  && (space_q < val_i)) ||
             ((mode_i == fpba_pkg::FIT_WORST) && (space_q > val_i));
    // strict compare keeps the lower index on a tie
    take   = ctl_i.valid && qual && (!ctl_i.found || better);
    ctl_d.valid = ctl_i.valid;
    ctl_d.found = ctl_i.found || (ctl_i.valid && qual);
    idx_d  = take ? MyIdx   : idx_i;
    val_d  = take ? space_q : val_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_q <= '0;
      ctl_q   <= '0;
    end else begin
      if (wr_en_i) begin
        space_q <= wr_data_i;
      end
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    val_q <= val_d;
  end

  assign ctl_o = ctl_q;
  assign idx_o = idx_q;
  assign val_o = val_q;

endmodule

### rtl/fpba_checker.sv
// Port-level checks for the fit-policy block allocator, bound to the top.
// Depends on fpba_pkg and fit_policy_block_allocator_unit.
module fpba_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic [0:0]                   s_axis_tuser_i,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [fpba_pkg::TDATA_W-1:0] m_axis_tdata_o,
  input logic [0:0]                   m_axis_tuser_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // a refused request reports zeros
  a_nogrant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("no-fit result carries data");

  // one command at a time
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second transfer taken while busy");

  // a load into an empty output register answers once the done state has written it
  a_load_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o &&
    (s_axis_tuser_i[0] == fpba_pkg::CMD_LOAD)
    |=> !m_axis_tvalid_o ##1 m_axis_tvalid_o)
    else $error("load result late");

endmodule

bind fit_policy_block_allocator_unit fpba_checker u_fpba_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

### bench/fit_policy_block_allocator_unit_tb.sv
// Self-checking bench for fit_policy_block_allocator_unit: streams load/allocate
// commands, sets fit_mode over APB and checks every result transfer.
// Depends on fpba_pkg and the RTL of the allocator.
`timescale 1ns / 100ps

module fit_policy_block_allocator_unit_tb;

  localparam int NUM_BLOCKS     = 8;
  localparam int SIZE_BITS      = 16;
  localparam int WATCHDOG_LIMIT = 2000;  // limit on idle cycles
  localparam int SETTLE_CYCLES  = 4;     // wait after the drain; all results already seen
  localparam int PHASE_ITEMS    = 220;
  localparam int HOLD_CYCLES    = 80;    // long receiver hold-off

  // fit_mode code 3 has no policy of its own and behaves as first fit
  localparam logic [fpba_pkg::MODE_W-1:0] FIT_SPARE = 2'd3;

  typedef struct packed {
    logic                           granted;
    logic [fpba_pkg::SLOT_W-1:0]    blk;
    logic [SIZE_BITS-1:0]           left;
  } alloc_result_t;

  // Tracks the free-space table and the policy, and holds the results still due.
  class alloc_scoreboard;
    logic [SIZE_BITS-1:0]        free_space_tbl [NUM_BLOCKS];
    logic [fpba_pkg::MODE_W-1:0] policy;
    alloc_result_t               expected_q [$];
    int                          errors;

    function new();
      foreach (free_space_tbl[i]) free_space_tbl[i] = '0;
      policy = fpba_pkg::FIT_FIRST;
      errors = 0;
    endfunction

    function void set_policy(logic [fpba_pkg::MODE_W-1:0] mode);
      policy = mode;
    endfunction

    function bit drained();
      return expected_q.size() == 0;
    endfunction

    // every slot code is below NUM_BLOCKS, so a load always lands
    function void note_command(fpba_pkg::cmd_e cmd, logic [fpba_pkg::SLOT_W-1:0] slot,
                               logic [SIZE_BITS-1:0] size);
      alloc_result_t r;
      bit            found;
      int            pick;
      r     = '0;
      found = 1'b0;
      pick  = 0;
      if (cmd == fpba_pkg::CMD_LOAD) begin
        free_space_tbl[slot] = size;
        r.granted = 1'b1;
        r.blk     = slot;
        r.left    = size;
      end else begin
        // lowest index wins ties; first fit never moves off the first match
        for (int j = 0; j < NUM_BLOCKS; j++) begin
          if (free_space_tbl[j] >= size) begin
            if (!found) begin
              found = 1'b1;
              pick  = j;
            end else if (policy == fpba_pkg::FIT_BEST &&
                         free_space_tbl[j] < free_space_tbl[pick]) begin
              pick = j;
            end else if (policy == fpba_pkg::FIT_WORST &&
                         free_space_tbl[j] > free_space_tbl[pick]) begin
              pick = j;
            end
          end
        end
        if (found) begin
          free_space_tbl[pick] = free_space_tbl[pick] - size;
          r.granted = 1'b1;
          r.blk     = fpba_pkg::SLOT_W'(pick);
          r.left    = free_space_tbl[pick];
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic granted, logic [fpba_pkg::SLOT_W-1:0] blk,
                               logic [SIZE_BITS-1:0] left);
      alloc_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with none due: granted=%0b block=%0d left=%0d",
                   $time, granted, blk, left);
        return;
      end
      want = expected_q.pop_front();
      if (want.granted !== granted || want.blk !== blk || want.left !== left) begin
        errors++;
        if (errors <= 10)
          $display("%0t: exp granted=%0b block=%0d left=%0d, got %0b %0d %0d",
                   $time, want.granted, want.blk, want.left, granted, blk, left);
      end
    endfunction
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             s_axis_tvalid_i;
  logic                             s_axis_tready_o;
  logic [fpba_pkg::TDATA_W-1:0]     s_axis_tdata_i;
  logic [0:0]                       s_axis_tuser_i;
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i;
  logic [fpba_pkg::TDATA_W-1:0]     m_axis_tdata_o;
  logic [0:0]                       m_axis_tuser_o;
  logic                             psel_i;
  logic                             penable_i;
  logic                             pwrite_i;
  logic [fpba_pkg::PADDR_W-1:0]     paddr_i;
  logic [31:0]                      pwdata_i;
  logic [31:0]                      prdata_o;
  logic                             pready_o;

  alloc_scoreboard sb;
  int              max_wait;      // idle draw range for both stream sides
  bit              hold_req;      // asks the receiver for one long hold-off
  int              idle_cycles;   // cycles since the last transfer on either stream

  fit_policy_block_allocator_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .psel_i          (psel_i),
    .penable_i       (penable_i),
    .pwrite_i        (pwrite_i),
    .paddr_i         (paddr_i),
    .pwdata_i        (pwdata_i),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Inputs only move at rising edges, so values seen at the falling edge are
  // exactly what the next rising edge samples. Both transfer monitors live here.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(m_axis_tuser_o[0], m_axis_tdata_o[fpba_pkg::SLOT_W-1:0],
                        m_axis_tdata_o[fpba_pkg::SLOT_W +: fpba_pkg::SIZE_FLD_W]);
      if (s_axis_tvalid_i && s_axis_tready_o)
        sb.note_command(fpba_pkg::cmd_e'(s_axis_tuser_i[0]),
                        s_axis_tdata_i[fpba_pkg::SLOT_W-1:0],
                        s_axis_tdata_i[fpba_pkg::SLOT_W +: fpba_pkg::SIZE_FLD_W]);
      if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  // Watchdog: a hang shows up as a long run of cycles with no transfer.
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("fit_policy_block_allocator_unit verification failed");
    $finish;
  end

  // Result side: random stalls per transfer, plus one long hold-off on request.
  initial begin
    int  stall;
    bit  taken;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = $urandom_range(0, max_wait);
      end
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
        @(negedge clk_i);
        taken = m_axis_tvalid_o;
        @(posedge clk_i);
      end
    end
  end

  // Offers one command and returns at the edge where the transfer happens.
  // tvalid stays high afterwards; the caller lowers it at the end of a phase.
  task automatic send_command(fpba_pkg::cmd_e cmd, logic [fpba_pkg::SLOT_W-1:0] slot,
                              logic [SIZE_BITS-1:0] size);
    int gap;
    bit taken;
    gap = $urandom_range(0, max_wait);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {{(fpba_pkg::TDATA_W - fpba_pkg::SIZE_FLD_W - fpba_pkg::SLOT_W){1'b0}},
                        size, slot};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = s_axis_tready_o;
      @(posedge clk_i);
    end
  endtask

  // Waits for the unit to drain, then writes fit_mode (setup + access cycle).
  task automatic set_fit_mode(logic [fpba_pkg::MODE_W-1:0] mode);
    s_axis_tvalid_i <= 1'b0;
    while (!sb.drained()) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= fpba_pkg::PADDR_W'(fpba_pkg::REG_FIT_MODE * 4);
    pwdata_i  <= {{(32 - fpba_pkg::MODE_W){1'b0}}, mode};
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    sb.set_policy(mode);
    @(posedge clk_i);
  endtask

  // Sizes lean toward small values so that fits, misses and ties are common.
  function automatic logic [SIZE_BITS-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return SIZE_BITS'($urandom_range(0, 64));
      6:          return SIZE_BITS'($urandom_range(0, 1024));
      default:    return SIZE_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    logic [fpba_pkg::MODE_W-1:0] phase_mode [8];
    fpba_pkg::cmd_e              cmd;
    phase_mode = '{fpba_pkg::FIT_BEST, fpba_pkg::FIT_WORST, FIT_SPARE, fpba_pkg::FIT_FIRST,
                   fpba_pkg::FIT_WORST, fpba_pkg::FIT_BEST, fpba_pkg::FIT_FIRST, FIT_SPARE};
    sb              = new();
    idle_cycles     = 0;
    max_wait        = 1;
    hold_req        = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    m_axis_tready_i = 1'b0;
    psel_i          = 1'b0;
    penable_i       = 1'b0;
    pwrite_i        = 1'b0;
    paddr_i         = '0;
    pwdata_i        = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. First fit straight out of reset: on the cleared table a
    // zero request still fits block 0, a request of one fits nowhere.
    send_command(fpba_pkg::CMD_ALLOC, 3'd5, 16'd0);
    send_command(fpba_pkg::CMD_ALLOC, 3'd2, 16'd1);
    send_command(fpba_pkg::CMD_LOAD,  3'd0, 16'd100);
    send_command(fpba_pkg::CMD_LOAD,  3'd1, 16'd50);
    send_command(fpba_pkg::CMD_LOAD,  3'd2, 16'd50);
    send_command(fpba_pkg::CMD_LOAD,  3'd3, 16'd200);
    send_command(fpba_pkg::CMD_LOAD,  3'd4, 16'd0);
    send_command(fpba_pkg::CMD_LOAD,  3'd5, 16'hFFFF);
    send_command(fpba_pkg::CMD_LOAD,  3'd6, 16'd30);
    send_command(fpba_pkg::CMD_LOAD,  3'd7, 16'd200);
    send_command(fpba_pkg::CMD_ALLOC, 3'd7, 16'd40);      // first fit -> block 0
    // best fit: blocks 1 and 2 tie at 50, lower index wins and empties
    set_fit_mode(fpba_pkg::FIT_BEST);
    send_command(fpba_pkg::CMD_ALLOC, 3'd0, 16'd50);
    send_command(fpba_pkg::CMD_ALLOC, 3'd0, 16'hFFFF);    // only block 5 can hold it
    // worst fit: blocks 3 and 7 tie at 200
    set_fit_mode(fpba_pkg::FIT_WORST);
    send_command(fpba_pkg::CMD_ALLOC, 3'd6, 16'd10);
    send_command(fpba_pkg::CMD_ALLOC, 3'd6, 16'hFFFF);    // no fit, table unchanged
    send_command(fpba_pkg::CMD_LOAD,  3'd5, 16'hFFFF);
    send_command(fpba_pkg::CMD_ALLOC, 3'd1, 16'd0);       // zero request leaves block 5 full
    // spare mode code behaves as first fit
    set_fit_mode(FIT_SPARE);
    send_command(fpba_pkg::CMD_ALLOC, 3'd4, 16'd60);
    send_command(fpba_pkg::CMD_ALLOC, 3'd4, 16'hFFFF);

    // Random phases, one policy each. Phase 0 runs without idling; phase 2
    // holds the result side off long enough for the input to back up.
    foreach (phase_mode[p]) begin
      set_fit_mode(phase_mode[p]);
      max_wait = (p == 0 || p == 2) ? 0 : 3;
      if (p == 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        cmd = ($urandom_range(0, 9) < 4) ? fpba_pkg::CMD_LOAD : fpba_pkg::CMD_ALLOC;
        send_command(cmd, fpba_pkg::SLOT_W'($urandom_range(0, 7)), pick_size());
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (!sb.drained()) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.drained()) begin
      $display("fit_policy_block_allocator_unit verification clean");
    end else begin
      $display("fit_policy_block_allocator_unit verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/fpba_pkg.sv
rtl/fpba_cell.sv
rtl/fit_policy_block_allocator_unit.sv
rtl/fpba_checker.sv
bench/fit_policy_block_allocator_unit_tb.sv
